[rtl/core/spq_pkg.sv]
// Shared types and codes for the sorted priority queue.
// Used by spq_ctrl, spq_dp and sorted_priority_queue_top; depends on nothing.
package spq_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned PRIO_W      = 32;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned OCC_W       = 7;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OCC_W - PRIO_W - DATA_W;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [DATA_W-1:0]        data;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture the input transaction
    logic prep;  // set up the walk for the captured item
    logic up;    // walk from the head: search, then close the gap
    logic dn;    // walk from the tail: open a gap for an insert
    logic put;   // write the new entry at the head slot
    logic fin;   // update count and load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              cnt_zero;
    logic              cnt_full;
    logic              rd_vld;
    logic              up_hit;
    logic              up_last;
    logic              dn_move;
    logic              dn_head;
  } sts_t;

endpackage

[rtl/core/spq_dp.sv]
// Datapath of the sorted priority queue: entry memory, count, walk pointers,
// compare logic and result register. Depends on spq_pkg; driven by spq_ctrl.
module spq_dp import spq_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [MODE_W-1:0]      in_tuser,
  output sts_t                   sts,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [STAT_W-1:0]      out_tuser
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  entry_t                   mem [CAPACITY];

  logic [CW-1:0]            cnt_r;
  logic [MODE_W-1:0]        mode_r;
  logic [DATA_W-1:0]        key_r;
  logic signed [PRIO_W-1:0] prio_r;
  logic [AW-1:0]            rd_ptr_r;
  logic [AW-1:0]            rd_ptr_nxt;
  logic [AW-1:0]            rd_a_r;
  entry_t                   rd_q_r;
  logic                     rd_vld_r;
  logic                     found_r;
  entry_t                   res_r;
  logic                     first_r;
  logic                     tail_less_r;
  logic [STAT_W-1:0]        stat_r;
  logic [DATA_W-1:0]        odata_r;
  logic signed [PRIO_W-1:0] oprio_r;
  logic [OCC_W-1:0]         occ_r;

  logic [CW-1:0]            cnt_m1;
  logic [AW-1:0]            last_a;
  logic                     full;
  logic                     zero;
  entry_t                   new_e;
  logic                     up_hit;
  logic                     new_lt;
  logic                     q_lt;
  logic                     head;
  logic                     tail_less;
  logic                     dn_move;
  logic                     rd_en;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  entry_t                   wr_e;
  logic [STAT_W-1:0]        stat_nxt;
  logic [CW-1:0]            cnt_nxt;

  assign cnt_m1 = cnt_r - CW'(1);
  assign last_a = cnt_m1[AW-1:0];
  assign full   = (cnt_r == CW'(CAPACITY));
  assign zero   = (cnt_r == '0);
  assign new_e  = '{prio: prio_r, data: key_r};

  // pop takes the head, the others match on the data word
  assign up_hit = rd_vld_r && !found_r &&
                  ((mode_r == MODE_POP) || (rd_q_r.data == key_r));

  assign new_lt    = (prio_r < rd_q_r.prio);
  assign q_lt      = (rd_q_r.prio < prio_r);
  assign head      = (rd_a_r == '0);
  // the first entry seen on the way down is the tail
  assign tail_less = first_r ? new_lt : tail_less_r;
  assign dn_move   = head ? new_lt : (tail_less && !q_lt);

  assign rd_en = cmd.up || cmd.dn;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_a_r;
    wr_e    = rd_q_r;
    if (cmd.up && rd_vld_r && found_r) begin
      wr_en   = 1'b1;
      wr_addr = rd_a_r - AW'(1);
    end
    if (cmd.dn && rd_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = rd_a_r + AW'(1);
      wr_e    = dn_move ? rd_q_r : new_e;
    end
    if (cmd.put) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_e    = new_e;
    end
  end

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    if (cmd.prep) begin
      rd_ptr_nxt = (mode_r == MODE_INSERT) ? last_a : '0;
    end else if (cmd.up) begin
      if (rd_ptr_r != last_a) begin
        rd_ptr_nxt = rd_ptr_r + AW'(1);
      end
    end else if (cmd.dn) begin
      if (rd_ptr_r != '0) begin
        rd_ptr_nxt = rd_ptr_r - AW'(1);
      end
    end
  end

  always_comb begin
    stat_nxt = ST_DONE;
    cnt_nxt  = cnt_r;
    case (mode_r)
      MODE_INSERT: begin
        if (full) begin
          stat_nxt = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      MODE_POP: begin
        if (found_r) begin
          cnt_nxt = cnt_m1;
        end else begin
          stat_nxt = ST_EMPTY;
        end
      end
      MODE_REMOVE: begin
        if (found_r) begin
          cnt_nxt = cnt_m1;
        end else begin
          stat_nxt = ST_MISSING;
        end
      end
      default: begin
        if (!found_r) begin
          stat_nxt = ST_MISSING;
        end
      end
    endcase
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_e;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_ptr_r];
      rd_a_r <= rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_ptr_r    <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      first_r     <= 1'b0;
      tail_less_r <= 1'b0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      if (cmd.prep) begin
        rd_vld_r <= 1'b0;
        found_r  <= 1'b0;
        first_r  <= 1'b1;
      end else begin
        if (rd_en) begin
          rd_vld_r <= 1'b1;
        end
        if (cmd.up && up_hit) begin
          found_r <= 1'b1;
        end
        if (cmd.dn && rd_vld_r) begin
          first_r <= 1'b0;
          if (first_r) begin
            tail_less_r <= new_lt;
          end
        end
      end
      if (cmd.fin) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_tuser;
      key_r  <= in_tdata[DATA_W-1:0];
      prio_r <= in_tdata[DATA_W +: PRIO_W];
    end
    if (cmd.up && up_hit) begin
      res_r <= rd_q_r;
    end
    if (cmd.fin) begin
      stat_r  <= stat_nxt;
      odata_r <= found_r ? res_r.data : '0;
      oprio_r <= found_r ? res_r.prio : '0;
      occ_r   <= OCC_W'(cnt_nxt);
    end
  end

  assign sts = '{mode: mode_r, cnt_zero: zero, cnt_full: full, rd_vld: rd_vld_r,
                 up_hit: up_hit, up_last: (rd_a_r == last_a), dn_move: dn_move,
                 dn_head: head};

  assign out_tdata = {{OUT_PAD_W{1'b0}}, occ_r, oprio_r, odata_r};
  assign out_tuser = stat_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.fin |=> $stable(cnt_r))
    else $error("entry count changed outside result update");

  a_found_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && mode_r == MODE_INSERT) |-> !found_r)
    else $error("search hit recorded during insert");

endmodule

[rtl/core/spq_ctrl.sv]
// Controller of the sorted priority queue: sequences load, walk and result
// update, and owns both handshakes. Depends on spq_pkg; drives spq_dp.
module spq_ctrl import spq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_UP   = 3'd2;
  localparam logic [2:0] S_DN   = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (sts.mode == MODE_INSERT) begin
          if (sts.cnt_full) begin
            state_nxt = S_FIN;
          end else if (sts.cnt_zero) begin
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_DN;
          end
        end else begin
          state_nxt = sts.cnt_zero ? S_FIN : S_UP;
        end
      end
      S_UP: begin
        cmd.up = 1'b1;
        // lookup stops at the hit, pop and remove close the gap up to the tail
        if (sts.rd_vld &&
            (sts.up_last || (sts.up_hit && sts.mode == MODE_LOOKUP))) begin
          state_nxt = S_FIN;
        end
      end
      S_DN: begin
        cmd.dn = 1'b1;
        if (sts.rd_vld) begin
          if (!sts.dn_move) begin
            state_nxt = S_FIN;
          end else if (sts.dn_head) begin
            state_nxt = S_PUT;
          end
        end
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the previous result has left the output register
        if (!out_valid_r || out_tready) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_tvalid)
    else $error("result update without output transaction");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_tready) |=> (state_r == S_FIN))
    else $error("result overwritten while output stalled");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.prep, cmd.up, cmd.dn, cmd.put, cmd.fin}))
    else $error("more than one datapath command at once");

endmodule

[rtl/core/sorted_priority_queue_top.sv]
// Sorted priority queue, up to CAPACITY entries in ascending priority order.
// Per item: load, prep, a walk one entry per cycle (from the head for pop, remove and
// lookup, from the tail for insert; none on an empty queue or a full insert), then the
// result update, which waits while the previous result stalls; one item at a time.
// Synchronous active-low reset empties the queue; memory is not cleared.
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // item_data, item_priority
  input  logic [MODE_W-1:0]      in_tuser,   // mode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_data, out_priority, occupancy, pad
  output logic [STAT_W-1:0]      out_tuser   // status
);

  cmd_t cmd;
  sts_t sts;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
